// File: design/multilevel_feedback_scheduler_unit_defines.svh
// Assertion macros shared by the scheduler RTL.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_UNIT_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define MFS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");
// next-cycle implication
`define MFS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");
`else
`define MFS_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define MFS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: design/mfs_pkg.sv
package mfs_pkg;

    localparam int LEVELS  = 3;
    localparam int LEVEL_W = 2;
    localparam int DATA_W  = 8;
    localparam int TIME_W  = 16;

    localparam logic [TIME_W-1:0]  TIME_MAX    = 16'hFFFF;
    localparam logic [LEVEL_W-1:0] LEVEL_TOP   = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_LAST  = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_END   = 2'd3;   // scan past the last level

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam int CFG_ADDR_W = 4;
    localparam logic [1:0] REG_QUANTUM0 = 2'd0;
    localparam logic [1:0] REG_QUANTUM1 = 2'd1;
    localparam logic [1:0] REG_QUANTUM2 = 2'd2;

    localparam logic [DATA_W-1:0] QUANTUM0_RESET = 8'd1;
    localparam logic [DATA_W-1:0] QUANTUM1_RESET = 8'd2;
    localparam logic [DATA_W-1:0] QUANTUM2_RESET = 8'd4;

    typedef struct packed {
        logic [DATA_W-1:0]  arrival;
        logic [DATA_W-1:0]  remaining;
        logic [LEVEL_W-1:0] level;
        logic               arrived;
    } slot_entry_t;

endpackage

// File: design/multilevel_feedback_scheduler_unit.sv
// Load word: written to the table in ST_IDLE; the block is ready again the next cycle.
// Tick word: a running slice goes start, run, hand-off; otherwise start (hand-off if no
//   work is left), scan one position or pass end per cycle over at most two passes,
//   then run and hand-off. Hand-off waits while the output register holds an untaken word.
// Synchronous active-low reset: slot table, time, scan position and slice cleared,
//   quanta back to 1/2/4; no clearing pass.
`include "multilevel_feedback_scheduler_unit_defines.svh"

module multilevel_feedback_scheduler_unit #(
    parameter int PROCESS_SLOTS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // slot[2:0], arrival_tick[10:3], service_ticks[18:11], zero
    input  logic [0:0]  s_tuser,   // operation
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // running_slot[2:0], run_level[4:3], all_done[5], zero
    output logic [0:0]  m_tuser,   // idle
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [mfs_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SLOT_W = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PROCESS_SLOTS - 1);

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;  // ready for a word
    localparam logic [2:0] ST_START = 3'd1;  // slice running? anything left?
    localparam logic [2:0] ST_SCAN  = 3'd2;  // one scan position per cycle
    localparam logic [2:0] ST_RUN   = 3'd3;  // one tick of the current slot
    localparam logic [2:0] ST_FIN   = 3'd4;  // hand result to output register

    logic [2:0] state_reg, state_next;

    logic [mfs_pkg::DATA_W-1:0]  q_reg [mfs_pkg::LEVELS];
    logic [mfs_pkg::TIME_W-1:0]  time_reg, time_next, time_inc;
    logic [mfs_pkg::LEVEL_W-1:0] scan_level_reg, scan_level_next;
    logic [SLOT_W-1:0]           scan_slot_reg, scan_slot_next;
    logic [SLOT_W-1:0]           cur_reg, cur_next;
    logic [mfs_pkg::DATA_W-1:0]  slice_reg, slice_next;
    logic                        ran_any_reg, ran_any_next;

    logic [SLOT_W-1:0]           res_slot_reg, res_slot_next;
    logic                        res_idle_reg, res_idle_next;
    logic [mfs_pkg::LEVEL_W-1:0] res_level_reg, res_level_next;

    logic                        m_valid_reg;
    logic [2:0]                  m_slot_reg;
    logic [mfs_pkg::LEVEL_W-1:0] m_level_reg;
    logic                        m_idle_reg;
    logic                        m_done_reg;

    // table access
    logic [SLOT_W-1:0]    tbl_idx;
    logic                 tbl_wr;
    mfs_pkg::slot_entry_t tbl_wdata, tbl_rdata;
    logic                 any_left;

    // input word fields
    logic                        in_op;
    logic [2:0]                  in_slot;
    logic [mfs_pkg::DATA_W-1:0]  in_arrival, in_service;
    logic [31:0]                 in_slot_wide;
    logic                        in_slot_ok;
    logic                        s_fire;
    logic [31:0]                 res_slot_wide;

    // scan datapath
    logic                        join_now;
    logic [mfs_pkg::LEVEL_W-1:0] lvl_eff;
    logic                        hit;
    logic [mfs_pkg::DATA_W-1:0]  q_sel, q_eff, slice_new;
    logic [mfs_pkg::DATA_W-1:0]  rem_dec;
    logic                        out_free;

    logic [1:0]                  cfg_idx;
    logic                        cfg_wr;

    assign in_op        = s_tuser[0];
    assign in_slot      = s_tdata[2:0];
    assign in_arrival   = s_tdata[10:3];
    assign in_service   = s_tdata[18:11];
    assign in_slot_wide = 32'(in_slot);
    assign in_slot_ok   = (in_slot_wide < 32'(PROCESS_SLOTS));

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign time_inc = (time_reg == mfs_pkg::TIME_MAX) ? time_reg
                                                      : time_reg + 16'd1;

    // a slot that has not joined yet does so once time reaches its arrival
    assign join_now = !tbl_rdata.arrived &&
                      ({8'd0, tbl_rdata.arrival} <= time_reg);
    assign lvl_eff  = join_now ? mfs_pkg::LEVEL_TOP : tbl_rdata.level;
    assign hit      = (tbl_rdata.arrived || join_now) &&
                      (lvl_eff == scan_level_reg) &&
                      (tbl_rdata.remaining != '0);

    always_comb begin
        case (lvl_eff)
            2'd0:    q_sel = q_reg[0];
            2'd1:    q_sel = q_reg[1];
            default: q_sel = q_reg[2];
        endcase
    end

    assign q_eff     = (q_sel == '0) ? 8'd1 : q_sel;
    assign slice_new = (tbl_rdata.remaining < q_eff) ? tbl_rdata.remaining : q_eff;
    assign rem_dec   = (tbl_rdata.remaining != '0) ? tbl_rdata.remaining - 8'd1
                                                   : tbl_rdata.remaining;

    mfs_slot_table #(
        .PROCESS_SLOTS(PROCESS_SLOTS),
        .SLOT_W       (SLOT_W)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .idx     (tbl_idx),
        .wr_en   (tbl_wr),
        .wr_data (tbl_wdata),
        .rd_data (tbl_rdata),
        .any_left(any_left)
    );

    // sequencer and shared slot datapath
    always_comb begin
        state_next      = state_reg;
        time_next       = time_reg;
        scan_level_next = scan_level_reg;
        scan_slot_next  = scan_slot_reg;
        cur_next        = cur_reg;
        slice_next      = slice_reg;
        ran_any_next    = ran_any_reg;
        res_slot_next   = res_slot_reg;
        res_idle_next   = res_idle_reg;
        res_level_next  = res_level_reg;
        tbl_idx         = cur_reg;
        tbl_wr          = 1'b0;
        tbl_wdata       = tbl_rdata;

        case (state_reg)
            ST_IDLE: begin
                tbl_idx = in_slot_wide[SLOT_W-1:0];
                if (s_fire) begin
                    if (in_op == mfs_pkg::OP_TICK) begin
                        state_next = ST_START;
                    end else if (in_slot_ok) begin
                        tbl_wr              = 1'b1;
                        tbl_wdata.arrival   = in_arrival;
                        tbl_wdata.remaining = in_service;
                        tbl_wdata.level     = mfs_pkg::LEVEL_TOP;
                        tbl_wdata.arrived   = 1'b0;
                        // reloading the running slot drops its slice
                        if (cur_reg == in_slot_wide[SLOT_W-1:0]) begin
                            slice_next = '0;
                        end
                    end
                end
            end
            ST_START: begin
                if (slice_reg != '0) begin
                    state_next = ST_RUN;
                end else if (!any_left) begin
                    // all work used up: idle, time held, pass restarts
                    scan_level_next = mfs_pkg::LEVEL_TOP;
                    scan_slot_next  = '0;
                    ran_any_next    = 1'b0;
                    res_slot_next   = '0;
                    res_idle_next   = 1'b1;
                    res_level_next  = '0;
                    state_next      = ST_FIN;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                tbl_idx = scan_slot_reg;
                if (scan_level_reg == mfs_pkg::LEVEL_END) begin
                    scan_level_next = mfs_pkg::LEVEL_TOP;
                    scan_slot_next  = '0;
                    ran_any_next    = 1'b0;
                    if (!ran_any_reg) begin
                        // empty pass: one idle tick
                        time_next      = time_inc;
                        res_slot_next  = '0;
                        res_idle_next  = 1'b1;
                        res_level_next = '0;
                        state_next     = ST_FIN;
                    end
                end else begin
                    if (join_now) begin
                        tbl_wr            = 1'b1;
                        tbl_wdata.arrived = 1'b1;
                        tbl_wdata.level   = mfs_pkg::LEVEL_TOP;
                    end
                    if (scan_slot_reg == LAST_SLOT) begin
                        scan_slot_next  = '0;
                        scan_level_next = scan_level_reg + 2'd1;
                    end else begin
                        scan_slot_next = scan_slot_reg + SLOT_W'(1);
                    end
                    if (hit) begin
                        cur_next     = scan_slot_reg;
                        slice_next   = slice_new;
                        ran_any_next = 1'b1;
                        state_next   = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                tbl_idx             = cur_reg;
                tbl_wr              = 1'b1;
                tbl_wdata.remaining = rem_dec;
                slice_next          = slice_reg - 8'd1;
                time_next           = time_inc;
                // slice used up with work left: drop a level, bottom level holds
                if ((slice_reg == 8'd1) && (rem_dec != '0) &&
                    (tbl_rdata.level < mfs_pkg::LEVEL_LAST)) begin
                    tbl_wdata.level = tbl_rdata.level + 2'd1;
                end
                res_slot_next  = cur_reg;
                res_idle_next  = 1'b0;
                res_level_next = tbl_rdata.level;
                state_next     = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            time_reg       <= '0;
            scan_level_reg <= mfs_pkg::LEVEL_TOP;
            scan_slot_reg  <= '0;
            cur_reg        <= '0;
            slice_reg      <= '0;
            ran_any_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            time_reg       <= time_next;
            scan_level_reg <= scan_level_next;
            scan_slot_reg  <= scan_slot_next;
            cur_reg        <= cur_next;
            slice_reg      <= slice_next;
            ran_any_reg    <= ran_any_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_slot_reg  <= res_slot_next;
        res_idle_reg  <= res_idle_next;
        res_level_reg <= res_level_next;
    end

    // output register; all_done is sampled after the tick has updated the table
    assign res_slot_wide = 32'(res_slot_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_FIN && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && out_free) begin
            m_slot_reg  <= res_slot_wide[2:0];
            m_level_reg <= res_level_reg;
            m_idle_reg  <= res_idle_reg;
            m_done_reg  <= !any_left;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_done_reg, m_level_reg, m_slot_reg};
    assign m_tuser  = m_idle_reg;

    // register port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg[0] <= mfs_pkg::QUANTUM0_RESET;
            q_reg[1] <= mfs_pkg::QUANTUM1_RESET;
            q_reg[2] <= mfs_pkg::QUANTUM2_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                mfs_pkg::REG_QUANTUM0: q_reg[0] <= pwdata[7:0];
                mfs_pkg::REG_QUANTUM1: q_reg[1] <= pwdata[7:0];
                mfs_pkg::REG_QUANTUM2: q_reg[2] <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            mfs_pkg::REG_QUANTUM0: prdata = {24'd0, q_reg[0]};
            mfs_pkg::REG_QUANTUM1: prdata = {24'd0, q_reg[1]};
            mfs_pkg::REG_QUANTUM2: prdata = {24'd0, q_reg[2]};
            default:               prdata = '0;
        endcase
    end

    // a tick of a slot is only ever run with slice left
    `MFS_ASSERT_IMPL(a_run_has_slice, aclk, aresetn, state_reg == ST_RUN, slice_reg != '0)
    // a run step always leads straight to a non-idle result
    `MFS_ASSERT_NEXT(a_run_to_fin, aclk, aresetn, state_reg == ST_RUN, state_reg == ST_FIN && !res_idle_reg)
    // an idle result carries neither slot nor level
    `MFS_ASSERT_IMPL(a_idle_clean, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[4:0] == 5'd0)
    // time never goes back
    `MFS_ASSERT_IMPL(a_time_mono, aclk, aresetn, $past(aresetn), time_reg >= $past(time_reg))

endmodule

// File: design/mfs_slot_table.sv
// Per-slot process state, one access address per cycle.
module mfs_slot_table #(
    parameter int PROCESS_SLOTS = 5,
    parameter int SLOT_W        = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [SLOT_W-1:0]    idx,
    input  logic                 wr_en,
    input  mfs_pkg::slot_entry_t wr_data,
    output mfs_pkg::slot_entry_t rd_data,
    output logic                 any_left
);

    mfs_pkg::slot_entry_t entry_reg [PROCESS_SLOTS];
    logic                 idx_ok;
    logic [PROCESS_SLOTS-1:0] busy;

    assign idx_ok = (32'(idx) < 32'(PROCESS_SLOTS));

    always_comb begin
        rd_data = '0;
        if (idx_ok) begin
            rd_data = entry_reg[idx];
        end
    end

    always_comb begin
        for (int i = 0; i < PROCESS_SLOTS; i++) begin
            busy[i] = (entry_reg[i].remaining != '0);
        end
    end

    assign any_left = |busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PROCESS_SLOTS; i++) begin
                entry_reg[i] <= '0;
            end
        end else if (wr_en && idx_ok) begin
            entry_reg[idx] <= wr_data;
        end
    end

endmodule

// File: test/tb_multilevel_feedback_scheduler_unit.sv
`timescale 1ns / 1ps

module tb_multilevel_feedback_scheduler_unit;

    localparam int PROCESS_SLOTS = 5;
    localparam int DRAIN_CYCLES  = 48;        // covers the worst tick when the output is free
    localparam int CYCLE_LIMIT   = 400_000;
    localparam int HOLD_CYCLES   = 300;       // long receiver hold-off
    localparam int PRINT_CAP     = 40;
    localparam int PHASE_WORDS   = 160;

    // One input word: operation, slot, arrival and service
    typedef struct packed {
        logic                       op;
        logic [2:0]                 slot;
        logic [mfs_pkg::DATA_W-1:0] arrival;
        logic [mfs_pkg::DATA_W-1:0] service;
    } sched_word_t;

    // One result word
    typedef struct packed {
        logic [2:0]                  slot;
        logic                        idle;
        logic [mfs_pkg::LEVEL_W-1:0] level;
        logic                        done;
    } sched_result_t;

    // Idling modes for the two stream sides
    typedef enum logic [2:0] {
        PH_STREAM,
        PH_SEND_GAPS,
        PH_RECV_STALL,
        PH_BOTH,
        PH_PRESSURE
    } idle_mode_t;

    // ------------------------------------------------------------------
    // Ports; every signal the bench drives starts at a known value
    // ------------------------------------------------------------------
    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [23:0]                    s_tdata  = '0;  // slot[2:0], arrival[10:3], service[18:11], zero
    logic [0:0]                     s_tuser  = '0;  // operation
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [7:0]                     m_tdata;        // running_slot[2:0], run_level[4:3], all_done[5], zero
    logic [0:0]                     m_tuser;        // idle
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [mfs_pkg::CFG_ADDR_W-1:0] paddr    = '0;
    logic [31:0]                    pwdata   = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    multilevel_feedback_scheduler_unit #(
        .PROCESS_SLOTS(PROCESS_SLOTS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Scheduler shadow: own copy of slot table, time, scan position,
    // slice and quanta, all at their reset values
    // ------------------------------------------------------------------
    logic [mfs_pkg::DATA_W-1:0]  quanta       [mfs_pkg::LEVELS] =
        '{mfs_pkg::QUANTUM0_RESET, mfs_pkg::QUANTUM1_RESET, mfs_pkg::QUANTUM2_RESET};
    logic [mfs_pkg::DATA_W-1:0]  arrival_of   [PROCESS_SLOTS] = '{default: '0};
    logic [mfs_pkg::DATA_W-1:0]  service_left [PROCESS_SLOTS] = '{default: '0};
    logic [mfs_pkg::LEVEL_W-1:0] level_of     [PROCESS_SLOTS] = '{default: '0};
    logic                        has_arrived  [PROCESS_SLOTS] = '{default: 1'b0};
    logic [mfs_pkg::TIME_W-1:0]  sched_time   = '0;
    logic [mfs_pkg::LEVEL_W-1:0] scan_lvl     = mfs_pkg::LEVEL_TOP;
    logic [2:0]                  scan_pos     = '0;
    logic [2:0]                  active_slot  = '0;
    logic [mfs_pkg::DATA_W-1:0]  slice_ticks  = '0;   // zero: no slice running
    logic                        pass_ran     = 1'b0;

    sched_word_t   pending_words    [$];
    sched_result_t expected_results [$];

    idle_mode_t idle_mode  = PH_STREAM;
    int         err_count  = 0;
    int         cycles     = 0;
    int         hold_left  = 0;
    bit         hold_done  = 1'b0;

    function automatic bit slots_all_done();
        for (int i = 0; i < PROCESS_SLOTS; i++)
            if (service_left[i] != 0) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void restart_pass();
        scan_lvl = mfs_pkg::LEVEL_TOP;
        scan_pos = '0;
        pass_ran = 1'b0;
    endfunction

    function automatic void advance_time();
        if (sched_time != mfs_pkg::TIME_MAX) sched_time++;
    endfunction

    // Walk from the scan position to the end of the pass. Late arrivals join
    // the top level as the scan passes them; a hit leaves the scan just past it.
    function automatic bit find_runnable(output logic [2:0] chosen);
        logic [2:0] i;
        bit         hit;
        chosen = '0;
        while (scan_lvl < mfs_pkg::LEVELS) begin
            i = scan_pos;
            if (!has_arrived[i] && arrival_of[i] <= sched_time) begin
                has_arrived[i] = 1'b1;
                level_of[i]    = mfs_pkg::LEVEL_TOP;
            end
            hit = has_arrived[i] && level_of[i] == scan_lvl && service_left[i] != 0;
            scan_pos++;
            if (scan_pos >= PROCESS_SLOTS) begin
                scan_pos = '0;
                scan_lvl++;
            end
            if (hit) begin
                chosen = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Apply one accepted word; returns 1 with the expected result for a tick
    function automatic bit schedule_word(input sched_word_t w, output sched_result_t r);
        logic [2:0]                  pick;
        logic [2:0]                  run;
        logic [mfs_pkg::LEVEL_W-1:0] lv;
        logic [mfs_pkg::DATA_W-1:0]  q;
        bit                          found;
        r = '0;
        if (w.op == mfs_pkg::OP_LOAD) begin
            // slots past the table are dropped
            if (w.slot < PROCESS_SLOTS) begin
                arrival_of[w.slot]   = w.arrival;
                service_left[w.slot] = w.service;
                level_of[w.slot]     = mfs_pkg::LEVEL_TOP;
                has_arrived[w.slot]  = 1'b0;
                // reloading the running slot cancels its slice
                if (slice_ticks != 0 && active_slot == w.slot) slice_ticks = '0;
            end
            return 1'b0;
        end
        if (slice_ticks == 0) begin
            // nothing left anywhere: idle and done, time frozen
            if (slots_all_done()) begin
                restart_pass();
                r.idle = 1'b1;
                r.done = 1'b1;
                return 1'b1;
            end
            found = find_runnable(pick);
            // a pass that ran something rolls straight into a new one
            if (!found && pass_ran) begin
                restart_pass();
                found = find_runnable(pick);
            end
            if (!found) begin
                advance_time();
                restart_pass();
                r.idle = 1'b1;
                return 1'b1;
            end
            q = quanta[level_of[pick]];
            if (q == 0) q = 1;   // zero quantum acts as one
            active_slot = pick;
            slice_ticks = (service_left[pick] < q) ? service_left[pick] : q;
            pass_ran    = 1'b1;
        end
        run = active_slot;
        lv  = level_of[run];
        if (service_left[run] != 0) service_left[run]--;
        slice_ticks--;
        advance_time();
        // slice used up with work left: demote, bottom level holds
        if (slice_ticks == 0 && service_left[run] != 0 && lv < mfs_pkg::LEVEL_LAST)
            level_of[run] = lv + 1'b1;
        r.slot  = run;
        r.level = lv;
        r.done  = slots_all_done();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: holds a word until taken, random gaps per mode
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : word_driver
        sched_word_t   word_on_bus;
        sched_result_t res;
        int            gap_pct;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (schedule_word(word_on_bus, res)) expected_results.push_back(res);
            end
            gap_pct = (idle_mode == PH_SEND_GAPS) ? 56 : (idle_mode == PH_BOTH) ? 6 : 0;
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                    word_on_bus = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, word_on_bus.service, word_on_bus.arrival,
                                 word_on_bus.slot};
                    s_tuser  <= word_on_bus.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each taken word against the oldest
    // expectation; also owns the receiver stalls and the long hold-off
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        sched_result_t want;
        sched_result_t got;
        int            stall_pct;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.slot  = m_tdata[2:0];
                got.level = m_tdata[4:3];
                got.done  = m_tdata[5];
                got.idle  = m_tuser[0];
                if (expected_results.size() == 0) begin
                    err_count++;
                    if (err_count <= PRINT_CAP)
                        $display("%0t: expected no result word, actual slot %0d idle %0d %s",
                                 $time, got.slot, got.idle,
                                 $sformatf("level %0d done %0d", got.level, got.done));
                end else begin
                    want = expected_results.pop_front();
                    if (got.slot !== want.slot) begin
                        err_count++;
                        if (err_count <= PRINT_CAP)
                            $display("%0t: running_slot expected %0d actual %0d",
                                     $time, want.slot, got.slot);
                    end
                    if (got.idle !== want.idle) begin
                        err_count++;
                        if (err_count <= PRINT_CAP)
                            $display("%0t: idle expected %0d actual %0d",
                                     $time, want.idle, got.idle);
                    end
                    if (got.level !== want.level) begin
                        err_count++;
                        if (err_count <= PRINT_CAP)
                            $display("%0t: run_level expected %0d actual %0d",
                                     $time, want.level, got.level);
                    end
                    if (got.done !== want.done) begin
                        err_count++;
                        if (err_count <= PRINT_CAP)
                            $display("%0t: all_done expected %0d actual %0d",
                                     $time, want.done, got.done);
                    end
                end
            end
            // long hold-off once, at the start of the pressure phase
            if (idle_mode == PH_PRESSURE && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            stall_pct = (idle_mode == PH_RECV_STALL) ? 56 : (idle_mode == PH_BOTH) ? 6 : 0;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_load(input logic [2:0] slot,
                              input logic [mfs_pkg::DATA_W-1:0] arrival,
                              input logic [mfs_pkg::DATA_W-1:0] service);
        sched_word_t w;
        w.op      = mfs_pkg::OP_LOAD;
        w.slot    = slot;
        w.arrival = arrival;
        w.service = service;
        pending_words.push_back(w);
    endtask

    task automatic queue_ticks(input int n);
        sched_word_t w;
        w = '0;
        w.op = mfs_pkg::OP_TICK;
        repeat (n) pending_words.push_back(w);
    endtask

    // Wait until every word is taken and answered, then let a load settle
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register write: setup then access cycle; only called while idle
    task automatic write_quantum(input logic [1:0] idx,
                                 input logic [mfs_pkg::DATA_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mfs_pkg::CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= {24'($urandom), val};   // upper bits are not part of the register
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        quanta[idx] = val;
    endtask

    task automatic set_quanta(input logic [mfs_pkg::DATA_W-1:0] q0,
                              input logic [mfs_pkg::DATA_W-1:0] q1,
                              input logic [mfs_pkg::DATA_W-1:0] q2);
        write_quantum(mfs_pkg::REG_QUANTUM0, q0);
        write_quantum(mfs_pkg::REG_QUANTUM1, q1);
        write_quantum(mfs_pkg::REG_QUANTUM2, q2);
    endtask

    // Mostly well-formed bursts: load some or all slots with mostly short work,
    // then ticks for the total work plus up to 6, capped at 48, with the odd reload
    // mid-run; the rest is raw noise over the full field ranges.
    task automatic queue_random_words(input int target);
        int          made;
        int          total;
        int          ticks;
        bit          every_slot;
        sched_word_t w;
        made = 0;
        while (made < target) begin
            if ($urandom_range(0, 99) < 80) begin
                total      = 0;
                every_slot = ($urandom_range(0, 99) < 40);
                for (int s = 0; s < PROCESS_SLOTS; s++) begin
                    if (every_slot || $urandom_range(0, 1)) begin
                        w.op      = mfs_pkg::OP_LOAD;
                        w.slot    = 3'(s);
                        w.arrival = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                                   : $urandom_range(0, 24));
                        w.service = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                                   : $urandom_range(0, 10));
                        pending_words.push_back(w);
                        total += w.service;
                        made++;
                    end
                end
                ticks = total + $urandom_range(0, 6);
                if (ticks > 48) ticks = 48;
                repeat (ticks) begin
                    if ($urandom_range(0, 99) < 3) begin
                        queue_load(3'($urandom_range(0, PROCESS_SLOTS - 1)),
                                   8'($urandom_range(0, 24)), 8'($urandom_range(0, 10)));
                        made++;
                    end
                    queue_ticks(1);
                    made++;
                end
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    w.op      = 1'($urandom_range(0, 1));
                    w.slot    = 3'($urandom_range(0, 7));
                    w.arrival = 8'($urandom_range(0, 255));
                    w.service = 8'($urandom_range(0, 255));
                    pending_words.push_back(w);
                    made++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, under the reset quanta 1/2/4
        idle_mode = PH_STREAM;
        queue_ticks(1);                 // empty table: done and idle, time frozen
        queue_load(3'd7, 8'd255, 8'd255);   // slot past the table, dropped
        queue_ticks(1);
        queue_load(3'd1, 8'd0, 8'd4);
        queue_load(3'd4, 8'd3, 8'd2);       // joins once time reaches 3
        queue_load(3'd0, 8'd0, 8'd0);       // nothing to do
        queue_ticks(8);                 // demotion to the bottom level, new passes
        queue_load(3'd1, 8'd0, 8'd6);       // reload, may cut a running slice
        queue_ticks(3);
        queue_load(3'd1, 8'd0, 8'd0);       // reload mid-slice
        queue_load(3'd2, 8'd200, 8'd1);     // far arrival: idle ticks advance time
        queue_ticks(4);
        queue_load(3'd2, 8'd0, 8'd0);
        queue_ticks(2);
        wait_idle();

        // Random phases, each under its own quanta and idling mode
        set_quanta(8'd1, 8'd1, 8'd1);
        idle_mode = PH_STREAM;
        queue_random_words(PHASE_WORDS);
        wait_idle();

        set_quanta(8'd255, 8'd255, 8'd255);
        idle_mode = PH_SEND_GAPS;
        queue_random_words(PHASE_WORDS);
        wait_idle();

        set_quanta(8'd0, 8'd0, 8'd0);       // zero quanta behave as one
        idle_mode = PH_RECV_STALL;
        queue_random_words(PHASE_WORDS);
        wait_idle();

        set_quanta(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                   8'($urandom_range(1, 255)));
        idle_mode = PH_BOTH;
        queue_random_words(PHASE_WORDS);
        wait_idle();

        // Receiver holds off while the sender keeps offering: input backs up
        set_quanta(8'd2, 8'd3, 8'd1);
        queue_random_words(PHASE_WORDS);
        idle_mode = PH_PRESSURE;
        wait_idle();

        if (err_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
